// ===== rtl/core/ntew_pkg.sv =====
// Package: widths, codes, enums and command/status structs for the number speller.
`default_nettype none

package ntew_pkg;

    localparam int VALUE_W   = 40;
    localparam int DIGITS    = 12;
    localparam int BCD_W     = DIGITS * 4;
    localparam int GROUP_W   = 12;
    localparam int GROUPS    = 4;
    localparam int GRP_IDX_W = 2;
    localparam int CODE_W    = 5;
    localparam int CNT_W     = $clog2(VALUE_W);

    localparam logic [VALUE_W-1:0] VALUE_MAX = 40'd999999999999;

    localparam logic [CODE_W-1:0] CODE_ZERO       = 5'd0;
    localparam logic [CODE_W-1:0] CODE_TEN        = 5'd10;
    localparam logic [CODE_W-1:0] CODE_TENS_ADJ   = 5'd18;  // twenty sits at tens digit 2
    localparam logic [CODE_W-1:0] CODE_HUNDRED    = 5'd28;
    localparam logic [CODE_W-1:0] CODE_SCALE_BASE = 5'd28;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SPECIAL,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_HDIG,
        PH_HWORD,
        PH_REST,
        PH_ONES,
        PH_SCALE
    } phase_t;

    typedef enum logic [2:0] {
        TOK_HDIG,
        TOK_HUNDRED,
        TOK_REST,
        TOK_ONES,
        TOK_SCALE,
        TOK_ZERO,
        TOK_ERR
    } tok_t;

    typedef struct packed {
        logic                 load;
        logic                 shift;
        logic                 emit;
        tok_t                 tok;
        logic                 last;
        logic [GRP_IDX_W-1:0] grp;
    } dp_cmd_t;

    typedef struct packed {
        logic oor;
        logic zero;
        logic hund_nz;
        logic rest_nz;
        logic teen;
        logic ones_nz;
        logic grp_nz;
        logic lower_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ntew_in_if.sv =====
// Input channel: one number to spell per item.
`default_nettype none

interface ntew_in_if
    import ntew_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ntew_out_if.sv =====
// Output channel: one word token per item.
`default_nettype none

interface ntew_out_if
    import ntew_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] word_code;
    logic              hyphen_before;
    logic              is_last;
    logic              out_of_range;

    modport source (output valid, output word_code, output hyphen_before,
                    output is_last, output out_of_range, input ready);
    modport sink   (input valid, input word_code, input hyphen_before,
                    input is_last, input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/number_to_english_words_top.sv =====
// Top level: spells a number as a run of English word tokens.
//
//  channel  dir  payload                                          handshake
//  din      in   value[39:0]                                      valid/ready
//  dout     out  word_code[4:0] hyphen_before is_last out_of_range valid/ready
//
//  One number at a time: the value is accepted, converted to BCD by shift-add-3,
//  then the sequencer steps through the group phases, one step per phase.
//  Zero and out-of-range values skip conversion and give a single token.
//  Reset is asynchronous and clears only the controller; no memories to sweep.
//  A stalled output holds the sequencer; din is ready again once the final
//  token is registered, even while that token still waits on dout.
`default_nettype none

module number_to_english_words_top
    import ntew_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    ntew_in_if.sink   din,
    ntew_out_if.source dout
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ntew_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ntew_dp u_dp (
        .clk           (clk),
        .value         (din.value),
        .cmd           (cmd),
        .stat          (stat),
        .word_code     (dout.word_code),
        .hyphen_before (dout.hyphen_before),
        .is_last       (dout.is_last),
        .out_of_range  (dout.out_of_range)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ntew_dp.sv =====
// Datapath: shift-add-3 binary to BCD converter, group decode and token register.
`default_nettype none

module ntew_dp
    import ntew_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [VALUE_W-1:0] value,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    output logic [CODE_W-1:0]       word_code,
    output logic                    hyphen_before,
    output logic                    is_last,
    output logic                    out_of_range
);

    logic [VALUE_W-1:0] value_reg, value_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic               oor_reg, oor_next;
    logic               zero_reg, zero_next;

    logic [CODE_W-1:0]  code_reg, code_next;
    logic               hyph_reg, hyph_next;
    logic               last_reg, last_next;
    logic               err_reg, err_next;

    logic [GROUP_W-1:0] grp_bits;
    logic [3:0]         dig_h, dig_t, dig_o;
    logic [GROUPS-1:0]  grp_nz_vec;
    logic [GROUPS-1:0]  lower_mask;
    logic [CODE_W-1:0]  rest_code;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        value_next = value_reg;
        bcd_next   = bcd_reg;
        oor_next   = oor_reg;
        zero_next  = zero_reg;
        if (cmd.load)
        begin
            value_next = value;
            bcd_next   = '0;
            oor_next   = (value > VALUE_MAX);
            zero_next  = (value == '0);
        end
        else if (cmd.shift)
        begin
            value_next = {value_reg[VALUE_W-2:0], 1'b0};
            bcd_next   = {bcd_adj[BCD_W-2:0], value_reg[VALUE_W-1]};
        end
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
            grp_nz_vec[g] = |bcd_reg[g*GROUP_W +: GROUP_W];
    end

    assign grp_bits   = bcd_reg[cmd.grp*GROUP_W +: GROUP_W];
    assign dig_h      = grp_bits[11:8];
    assign dig_t      = grp_bits[7:4];
    assign dig_o      = grp_bits[3:0];
    assign lower_mask = (GROUPS'(1) << cmd.grp) - GROUPS'(1);

    always_comb
    begin
        stat.oor        = oor_reg;
        stat.zero       = zero_reg;
        stat.hund_nz    = (dig_h != 4'd0);
        stat.rest_nz    = (dig_t != 4'd0) || (dig_o != 4'd0);
        stat.teen       = (dig_t < 4'd2);
        stat.ones_nz    = (dig_o != 4'd0);
        stat.grp_nz     = grp_nz_vec[cmd.grp];
        stat.lower_zero = ((grp_nz_vec & lower_mask) == '0);
    end

    // below twenty: ten plus ones for the teens; otherwise a tens word
    always_comb
    begin
        if (dig_t < 4'd2)
            rest_code = dig_t[0] ? (CODE_TEN + {1'b0, dig_o}) : {1'b0, dig_o};
        else
            rest_code = CODE_TENS_ADJ + {1'b0, dig_t};
    end

    always_comb
    begin
        code_next = code_reg;
        hyph_next = hyph_reg;
        last_next = last_reg;
        err_next  = err_reg;
        if (cmd.emit)
        begin
            hyph_next = 1'b0;
            last_next = cmd.last;
            err_next  = 1'b0;
            unique case (cmd.tok)
                TOK_HDIG:    code_next = {1'b0, dig_h};
                TOK_HUNDRED: code_next = CODE_HUNDRED;
                TOK_REST:    code_next = rest_code;
                TOK_ONES:
                begin
                    code_next = {1'b0, dig_o};
                    hyph_next = 1'b1;
                end
                TOK_SCALE:   code_next = CODE_SCALE_BASE + {{(CODE_W-GRP_IDX_W){1'b0}}, cmd.grp};
                TOK_ZERO:    code_next = CODE_ZERO;
                TOK_ERR:
                begin
                    code_next = CODE_ZERO;
                    err_next  = 1'b1;
                end
                default:     code_next = CODE_ZERO;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        bcd_reg   <= bcd_next;
        oor_reg   <= oor_next;
        zero_reg  <= zero_next;
        code_reg  <= code_next;
        hyph_reg  <= hyph_next;
        last_reg  <= last_next;
        err_reg   <= err_next;
    end

    assign word_code     = code_reg;
    assign hyphen_before = hyph_reg;
    assign is_last       = last_reg;
    assign out_of_range  = err_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ntew_ctrl.sv =====
// Controller: conversion counter and group/phase sequencer for token emission.
`default_nettype none

module ntew_ctrl
    import ntew_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [CNT_W-1:0] CntLast = CNT_W'(VALUE_W - 1);

    ctrl_state_t          state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [GRP_IDX_W-1:0] grp_reg, grp_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;
    logic                 end_grp;

    assign slot_free = !out_valid_reg || out_ready;
    assign end_grp   = (grp_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_HDIG;
            cnt_reg       <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        grp_next   = grp_reg;
        cmd.load   = 1'b0;
        cmd.shift  = 1'b0;
        cmd.emit   = 1'b0;
        cmd.tok    = TOK_HDIG;
        cmd.last   = 1'b0;
        cmd.grp    = grp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (stat.oor || stat.zero)
                    state_next = ST_SPECIAL;
                else
                begin
                    cmd.shift = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CntLast)
                    begin
                        grp_next   = GRP_IDX_W'(GROUPS - 1);
                        phase_next = PH_HDIG;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SPECIAL:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.tok    = stat.oor ? TOK_ERR : TOK_ZERO;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    unique case (phase_reg)
                        PH_HDIG:
                        begin
                            if (!stat.grp_nz)
                            begin
                                // empty group: no tokens, move down
                                if (end_grp)
                                    state_next = ST_IDLE;
                                grp_next = grp_reg - GRP_IDX_W'(1);
                            end
                            else
                            begin
                                cmd.emit   = stat.hund_nz;
                                cmd.tok    = TOK_HDIG;
                                phase_next = PH_HWORD;
                            end
                        end
                        PH_HWORD:
                        begin
                            cmd.emit   = stat.hund_nz;
                            cmd.tok    = TOK_HUNDRED;
                            cmd.last   = !stat.rest_nz && end_grp;
                            phase_next = PH_REST;
                        end
                        PH_REST:
                        begin
                            cmd.emit   = stat.rest_nz;
                            cmd.tok    = TOK_REST;
                            cmd.last   = end_grp && (stat.teen || !stat.ones_nz);
                            phase_next = PH_ONES;
                        end
                        PH_ONES:
                        begin
                            cmd.emit   = stat.rest_nz && !stat.teen && stat.ones_nz;
                            cmd.tok    = TOK_ONES;
                            cmd.last   = end_grp;
                            phase_next = PH_SCALE;
                        end
                        PH_SCALE:
                        begin
                            cmd.emit   = !end_grp;
                            cmd.tok    = TOK_SCALE;
                            cmd.last   = stat.lower_zero;
                            phase_next = PH_HDIG;
                            if (end_grp)
                                state_next = ST_IDLE;
                            grp_next = grp_reg - GRP_IDX_W'(1);
                        end
                        default:
                        begin
                            phase_next = PH_HDIG;
                        end
                    endcase
                    if (cmd.emit && cmd.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("token issued while output slot occupied");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after final token");

    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONV) && (cnt_reg == '0))
        else $error("accepted item did not start conversion");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (cnt_reg <= CntLast))
        else $error("conversion counter overran");
`endif

endmodule

`default_nettype wire

// ===== verif/number_to_english_words_top_test.sv =====
// Testbench for number_to_english_words_top: random and corner numbers, word tokens checked.
`timescale 1ns / 1ps

module number_to_english_words_top_test
    import ntew_pkg::*;
();

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 210;
    localparam int MAX_GAP      = 14;
    localparam int SETTLE       = 100;

    typedef struct packed {
        logic [CODE_W-1:0] word_code;
        logic              hyphen_before;
        logic              is_last;
        logic              out_of_range;
    } word_t;

    // Spells each accepted number into the tokens it should produce and
    // checks the block's tokens against them in order.
    class word_checker;
        word_t words_due[$];
        word_t run[$];
        int    numbers;
        int    rejected;
        int    checked;
        int    longest;
        int    errors;

        function void add_word(logic [CODE_W-1:0] code, logic hyphen);
            word_t w;
            w.word_code     = code;
            w.hyphen_before = hyphen;
            w.is_last       = 1'b0;
            w.out_of_range  = 1'b0;
            run.push_back(w);
        endfunction

        function void note_number(logic [VALUE_W-1:0] v);
            longint unsigned rest;
            int unsigned     grp [GROUPS];
            int unsigned     hund;
            int unsigned     low;
            word_t           w;
            int              g;
            numbers++;
            run.delete();
            if (v > VALUE_MAX) begin
                rejected++;
                add_word(CODE_ZERO, 1'b0);
                run[0].out_of_range = 1'b1;
            end else if (v == '0) begin
                add_word(CODE_ZERO, 1'b0);
            end else begin
                rest = 64'(v);
                for (g = 0; g < GROUPS; g++) begin
                    grp[g] = 32'(rest % 1000);
                    rest   = rest / 1000;
                end
                for (g = GROUPS - 1; g >= 0; g--) begin
                    if (grp[g] != 0) begin
                        hund = grp[g] / 100;
                        low  = grp[g] % 100;
                        if (hund != 0) begin
                            add_word(CODE_W'(hund), 1'b0);
                            add_word(CODE_HUNDRED, 1'b0);
                        end
                        if (low != 0 && low < 20) begin
                            add_word(CODE_W'(low), 1'b0);
                        end else if (low != 0) begin
                            add_word(CODE_W'(low / 10) + CODE_TENS_ADJ, 1'b0);
                            if (low % 10 != 0)
                                add_word(CODE_W'(low % 10), 1'b1);
                        end
                        if (g != 0)
                            add_word(CODE_SCALE_BASE + CODE_W'(g), 1'b0);
                    end
                end
            end
            if (run.size() > longest)
                longest = run.size();
            for (g = 0; g < run.size(); g++) begin
                w = run[g];
                w.is_last = (g == run.size() - 1);
                words_due.push_back(w);
            end
        endfunction

        function void check_word(word_t got);
            word_t want;
            checked++;
            if (words_due.size() == 0) begin
                $error("token with no number pending: word_code %0d", got.word_code);
                errors++;
                return;
            end
            want = words_due.pop_front();
            if (got.word_code !== want.word_code) begin
                $error("word_code: expected %0d, got %0d", want.word_code, got.word_code);
                errors++;
            end
            if (got.hyphen_before !== want.hyphen_before) begin
                $error("hyphen_before: expected %0b, got %0b",
                       want.hyphen_before, got.hyphen_before);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("is_last: expected %0b, got %0b", want.is_last, got.is_last);
                errors++;
            end
            if (got.out_of_range !== want.out_of_range) begin
                $error("out_of_range: expected %0b, got %0b",
                       want.out_of_range, got.out_of_range);
                errors++;
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        fast_phase;
    int          cycles;
    word_checker sb;

    ntew_in_if  din_if();
    ntew_out_if dout_if();

    number_to_english_words_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still due", cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_gap();
        return fast_phase ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Groups of 0 to 999, weighted toward zero, values below twenty, round tens and hundreds.
    function automatic longint unsigned random_group();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return 64'($urandom_range(1, 19));
            2:       return 64'd10 * 64'($urandom_range(2, 9));
            3:       return 64'd100 * 64'($urandom_range(1, 9));
            default: return 64'($urandom_range(0, 999));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_number();
        longint unsigned span;
        longint unsigned v;
        span = 64'd1099511627775 - 64'(VALUE_MAX);
        case ($urandom_range(0, 9))
            0: v = 64'(VALUE_MAX) + 1 + ({$urandom, $urandom} % span);
            1: v = 64'($urandom_range(0, 999));
            2: v = {$urandom, $urandom} % 64'd1099511627776;
            default: v = random_group() * 64'd1000000000 + random_group() * 64'd1000000
                       + random_group() * 64'd1000 + random_group();
        endcase
        return VALUE_W'(v);
    endfunction

    task automatic send_number(input logic [VALUE_W-1:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge clk) din_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        din_if.valid <= 1'b1;
        din_if.value <= v;
        @(posedge clk);
        while (!(din_if.valid && din_if.ready))
            @(posedge clk);
        sb.note_number(din_if.value);
    endtask

    task automatic drain_words();
        @(negedge clk) din_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Output side: random stall before each token, none during fast phases.
    initial
    begin
        int    stall;
        word_t got;
        dout_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                @(negedge clk) dout_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) dout_if.ready <= 1'b1;
            @(posedge clk);
            while (!(dout_if.valid && dout_if.ready))
                @(posedge clk);
            got.word_code     = dout_if.word_code;
            got.hyphen_before = dout_if.hyphen_before;
            got.is_last       = dout_if.is_last;
            got.out_of_range  = dout_if.out_of_range;
            sb.check_word(got);
        end
    end

    initial
    begin
        longint unsigned corner_values [24];
        int i;
        corner_values = '{
            0, 1, 9, 10, 13, 19, 20, 21, 99, 100, 101, 115, 999, 1000, 1001,
            1000000, 1000000000, 12000017, 70000000090, 100000000000,
            999999999999, 1000000000000, 64'hFF_FFFF_FFFF, 64'hAA_5555_AAAA
        };
        sb            = new();
        cycles        = 0;
        fast_phase    = 1'b0;
        rst_n         = 1'b0;
        din_if.valid  = 1'b0;
        din_if.value  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        foreach (corner_values[k])
            send_number(VALUE_W'(corner_values[k]));
        drain_words();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 30)
                fast_phase = 1'b1;
            else if (i % 50 == 45)
                fast_phase = 1'b0;
            if (i == RANDOM_ITEMS / 2)
                drain_words();
            send_number(random_number());
        end
        @(negedge clk) din_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("spelled %0d numbers (%0d out of range), checked %0d tokens, longest run %0d",
                 sb.numbers, sb.rejected, sb.checked, sb.longest);
        $display("stalls of 0..%0d cycles on both sides, with back-to-back stretches",
                 MAX_GAP);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
